@@ sv/mlt_pkg.sv @@
`default_nettype none

package mlt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PORT_COUNT    = 16;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int AGE_W  = 8;
    localparam int AGED_W = 7;
    localparam int TMO_W  = 8;
    localparam int REQ_W  = 2;

    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(30);

    // request codes as they arrive on req_type
    localparam logic [REQ_W-1:0] REQ_LOOKUP = REQ_W'(0);
    localparam logic [REQ_W-1:0] REQ_LEARN  = REQ_W'(1);
    localparam logic [REQ_W-1:0] REQ_TICK   = REQ_W'(2);

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOOKUP,
        OP_LEARN,
        OP_TICK
    } op_t;

    // transaction token that walks the cell chain, collecting results
    typedef struct packed {
        logic              vld;
        op_t               op;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic              hit;
        logic [PORT_W-1:0] port_out;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic [AGED_W-1:0] aged;
    } tok_t;

    // write of a new entry into the slot picked during the walk
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } wr_t;

endpackage

`default_nettype wire

@@ sv/mlt_cell.sv @@
`default_nettype none

module mlt_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [mlt_pkg::IDX_W-1:0]     cell_idx,
    input  wire logic [mlt_pkg::TMO_W-1:0]     age_timeout,
    input  wire mlt_pkg::wr_t                  wr,
    input  wire mlt_pkg::tok_t                 tok_in,
    output mlt_pkg::tok_t                      tok_out
);

    logic                         valid_reg, valid_next;
    logic [mlt_pkg::MAC_W-1:0]    mac_reg, mac_next;
    logic [mlt_pkg::PORT_W-1:0]   port_reg, port_next;
    logic [mlt_pkg::AGE_W-1:0]    age_reg, age_next;
    mlt_pkg::tok_t                tok_reg, tok_next;

    logic                         match;
    logic [mlt_pkg::AGE_W-1:0]    age_inc;

    assign match   = valid_reg && (mac_reg == tok_in.mac);
    assign age_inc = (age_reg == mlt_pkg::AGE_MAX) ? age_reg
                                                    : age_reg + mlt_pkg::AGE_W'(1);

    always_comb
    begin
        valid_next = valid_reg;
        mac_next   = mac_reg;
        port_next  = port_reg;
        age_next   = age_reg;
        tok_next   = tok_in;

        if (tok_in.vld)
        begin
            case (tok_in.op)
                mlt_pkg::OP_LOOKUP:
                begin
                    if (match && !tok_in.hit)
                    begin
                        tok_next.hit      = 1'b1;
                        tok_next.port_out = port_reg;
                    end
                end
                mlt_pkg::OP_LEARN:
                begin
                    if (match && !tok_in.hit)
                    begin
                        tok_next.hit = 1'b1;
                        port_next    = tok_in.port;
                        age_next     = '0;
                    end
                    // remember the lowest free slot in case nothing matches
                    if (!valid_reg && !tok_in.free_found)
                    begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = cell_idx;
                    end
                end
                mlt_pkg::OP_TICK:
                begin
                    if (valid_reg)
                    begin
                        age_next = age_inc;
                        if (age_inc > age_timeout)
                        begin
                            valid_next    = 1'b0;
                            tok_next.aged = tok_in.aged + mlt_pkg::AGED_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // new entry placed after the walk has finished
        if (wr.en && (wr.idx == cell_idx))
        begin
            valid_next = 1'b1;
            mac_next   = wr.mac;
            port_next  = wr.port;
            age_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg  <= mac_next;
        port_reg <= port_next;
        age_reg  <= age_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ sv/mac_learning_table_with_aging.sv @@
`default_nettype none

// channel   signals                                   direction
// input     in_valid, in_ready, req_type,             into block
//           mac_addr, port_in
// output    out_valid, out_ready, hit, port_out,      out of block
//           learned_new, table_full, aged_count
// config    cfg_we, cfg_wdata (age_timeout)           into block
//
// one transaction at a time: it walks the chain of TABLE_ENTRIES cells, one cell
// per cycle, then the finish state places a new entry and loads the result register.
// reset empties the table at once and sets age_timeout to 30.
// a result waiting on out_ready holds the finished transaction; the next one is
// accepted as soon as the result register has been loaded.

module mac_learning_table_with_aging (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [mlt_pkg::TMO_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mlt_pkg::REQ_W-1:0]     req_type,
    input  wire logic [mlt_pkg::MAC_W-1:0]     mac_addr,
    input  wire logic [mlt_pkg::PORT_W-1:0]    port_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic [mlt_pkg::PORT_W-1:0]         port_out,
    output logic                               learned_new,
    output logic                               table_full,
    output logic [mlt_pkg::AGED_W-1:0]         aged_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    logic [mlt_pkg::TMO_W-1:0]    age_timeout_reg;
    mlt_pkg::tok_t                tok0_reg;
    mlt_pkg::tok_t                held_reg;
    logic                         out_valid_reg;
    logic                         hit_reg;
    logic [mlt_pkg::PORT_W-1:0]   port_out_reg;
    logic                         learned_new_reg;
    logic                         table_full_reg;
    logic [mlt_pkg::AGED_W-1:0]   aged_count_reg;

    mlt_pkg::tok_t                tok [mlt_pkg::TABLE_ENTRIES+1];
    mlt_pkg::wr_t                 wr;
    mlt_pkg::op_t                 in_op;
    mlt_pkg::tok_t                in_tok;
    logic                         accept;
    logic                         out_free;
    logic                         finish;
    logic                         is_new_learn;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        unique case (req_type)
            mlt_pkg::REQ_LOOKUP: in_op = mlt_pkg::OP_LOOKUP;
            mlt_pkg::REQ_LEARN:
                // a learn on a port the switch does not have is dropped
                in_op = (32'(port_in) < mlt_pkg::PORT_COUNT) ? mlt_pkg::OP_LEARN
                                                              : mlt_pkg::OP_NONE;
            mlt_pkg::REQ_TICK:   in_op = mlt_pkg::OP_TICK;
            default:             in_op = mlt_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        in_tok            = '0;
        in_tok.vld        = 1'b1;
        in_tok.op         = in_op;
        in_tok.mac        = mac_addr;
        in_tok.port       = port_in;
    end

    assign tok[0] = tok0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < mlt_pkg::TABLE_ENTRIES; gi++)
        begin : g_cell
            mlt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cell_idx    (mlt_pkg::IDX_W'(gi)),
                .age_timeout (age_timeout_reg),
                .wr          (wr),
                .tok_in      (tok[gi]),
                .tok_out     (tok[gi+1])
            );
        end
    endgenerate

    assign is_new_learn = (held_reg.op == mlt_pkg::OP_LEARN) && !held_reg.hit;

    always_comb
    begin
        wr      = '0;
        wr.en   = finish && is_new_learn && held_reg.free_found;
        wr.idx  = held_reg.free_idx;
        wr.mac  = held_reg.mac;
        wr.port = held_reg.port;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            age_timeout_reg <= mlt_pkg::TIMEOUT_RESET;
            tok0_reg        <= '0;
            held_reg        <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            port_out_reg    <= '0;
            learned_new_reg <= 1'b0;
            table_full_reg  <= 1'b0;
            aged_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                age_timeout_reg <= cfg_wdata;

            if (accept)
                tok0_reg <= in_tok;
            else
                tok0_reg.vld <= 1'b0;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_WALK;
                end
                ST_WALK:
                begin
                    if (tok[mlt_pkg::TABLE_ENTRIES].vld)
                    begin
                        held_reg  <= tok[mlt_pkg::TABLE_ENTRIES];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        hit_reg         <= held_reg.hit;
                        port_out_reg    <= held_reg.port_out;
                        learned_new_reg <= is_new_learn && held_reg.free_found;
                        table_full_reg  <= is_new_learn && !held_reg.free_found;
                        aged_count_reg  <= held_reg.aged;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign port_out    = port_out_reg;
    assign learned_new = learned_new_reg;
    assign table_full  = table_full_reg;
    assign aged_count  = aged_count_reg;

endmodule

`default_nettype wire
